>>> hdl/ccbm_pkg.sv
// ----------------------------------------------------------------------------
// ccbm_pkg
// shared types and constants for the camera cartridge bank mapper
// ----------------------------------------------------------------------------
package ccbm_pkg;

   // access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // target codes
   localparam logic [2:0] TGT_NONE  = 3'd0;
   localparam logic [2:0] TGT_ROM   = 3'd1;
   localparam logic [2:0] TGT_RAM   = 3'd2;
   localparam logic [2:0] TGT_CAMIO = 3'd3;
   localparam logic [2:0] TGT_REG   = 3'd4;

   // bank register numbers reported as offset for register writes
   localparam logic [22:0] REG_RAM_ENABLE  = 23'd0;
   localparam logic [22:0] REG_ROM_LOW     = 23'd1;
   localparam logic [22:0] REG_ROM_HIGH    = 23'd2;
   localparam logic [22:0] REG_RAM_SELECT  = 23'd3;

   // address ranges and fill values
   localparam logic [15:0] EXT_FIRST    = 16'hA000;
   localparam logic [15:0] STATUS_LAST  = 16'hA035;
   localparam logic [15:0] IMAGE_FIRST  = 16'hA100;
   localparam logic [15:0] IMAGE_LAST   = 16'hAEFF;
   localparam logic [7:0]  IMAGE_FILL   = 8'hCC;
   localparam logic [7:0]  STATUS_FILL  = 8'h00;
   localparam int          CAMIO_BIT    = 4;

   localparam logic [7:0]  ROM_LOW_RESET = 8'd1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] bus_address;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [22:0] phys_offset;
      logic        force_read;
      logic [7:0]  forced_value;
   } rsp_type;

endpackage

>>> hdl/camera_cart_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// camera_cart_bank_mapper_top
// decodes cpu bus accesses of a camera cartridge into target space and offset
// one word per cycle while the response side does not stall: request register, decode, response register
// reset: synchronous, active high; ram off, rom bank 1, camera io deselected
// ----------------------------------------------------------------------------
module camera_cart_bank_mapper_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ccbm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ccbm_pkg::rsp_type rsp_data
);

   // request register
   logic              req_valid_ff;
   ccbm_pkg::req_type req_item_ff;

   // response register
   logic              rsp_valid_ff;
   ccbm_pkg::rsp_type rsp_item_ff;
   ccbm_pkg::rsp_type rsp_item_in;

   // bank registers
   logic       ram_enabled_ff,     ram_enabled_in;
   logic [7:0] rom_bank_low_ff,    rom_bank_low_in;
   logic       rom_bank_high_ff,   rom_bank_high_in;
   logic [4:0] ram_bank_select_ff, ram_bank_select_in;

   // handshake
   logic rsp_open;   // response register can take a word this cycle
   logic advance;    // request word moves into the decode
   logic req_take;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_open;
   // request register is free when empty or draining this cycle
   assign req_stall = req_valid_ff && !rsp_open;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // decode of the held request word
   logic        wr;
   logic [15:0] addr;
   logic [7:0]  wdata;
   logic        cam;
   logic        in_ext;

   always_comb begin
      wr     = req_item_ff.opcode == ccbm_pkg::OP_WRITE;
      addr   = req_item_ff.bus_address;
      wdata  = req_item_ff.data_byte;
      cam    = ram_bank_select_ff[ccbm_pkg::CAMIO_BIT];
      in_ext = addr[15:13] == 3'b101;

      rsp_item_in              = '0;
      rsp_item_in.target       = ccbm_pkg::TGT_NONE;
      ram_enabled_in           = ram_enabled_ff;
      rom_bank_low_in          = rom_bank_low_ff;
      rom_bank_high_in         = rom_bank_high_ff;
      ram_bank_select_in       = ram_bank_select_ff;

      if (in_ext) begin
         // external window: camera io or banked save ram
         if (cam) begin
            rsp_item_in.target      = ccbm_pkg::TGT_CAMIO;
            rsp_item_in.phys_offset = {10'd0, addr[12:0]};
         end else if (ram_enabled_ff) begin
            rsp_item_in.target      = ccbm_pkg::TGT_RAM;
            rsp_item_in.phys_offset = {6'd0, ram_bank_select_ff[3:0], addr[12:0]};
         end
      end else if (!wr) begin
         if (!addr[15]) begin
            rsp_item_in.target = ccbm_pkg::TGT_ROM;
            if (!addr[14]) begin
               // fixed bank
               rsp_item_in.phys_offset = {9'd0, addr[13:0]};
            end else begin
               // switchable bank, bank number used as written
               rsp_item_in.phys_offset = {rom_bank_high_ff, rom_bank_low_ff, addr[13:0]};
            end
         end
      end else begin
         // control register writes
         if (addr[15:13] == 3'b000) begin
            ram_enabled_in          = wdata != 8'd0;
            rsp_item_in.target      = ccbm_pkg::TGT_REG;
            rsp_item_in.phys_offset = ccbm_pkg::REG_RAM_ENABLE;
         end else if (addr[15:12] == 4'b0010) begin
            rom_bank_low_in         = wdata;
            rsp_item_in.target      = ccbm_pkg::TGT_REG;
            rsp_item_in.phys_offset = ccbm_pkg::REG_ROM_LOW;
         end else if (addr[15:12] == 4'b0011) begin
            rom_bank_high_in        = wdata[0];
            rsp_item_in.target      = ccbm_pkg::TGT_REG;
            rsp_item_in.phys_offset = ccbm_pkg::REG_ROM_HIGH;
         end else if (addr[15:13] == 3'b010) begin
            ram_bank_select_in      = wdata[4:0];
            rsp_item_in.target      = ccbm_pkg::TGT_REG;
            rsp_item_in.phys_offset = ccbm_pkg::REG_RAM_SELECT;
         end
      end

      // forced read data, from address and mode only
      if (!wr) begin
         if (cam && addr >= ccbm_pkg::EXT_FIRST && addr <= ccbm_pkg::STATUS_LAST) begin
            rsp_item_in.force_read   = 1'b1;
            rsp_item_in.forced_value = ccbm_pkg::STATUS_FILL;
         end else if (!cam && addr >= ccbm_pkg::IMAGE_FIRST
                      && addr <= ccbm_pkg::IMAGE_LAST) begin
            rsp_item_in.force_read   = 1'b1;
            rsp_item_in.forced_value = ccbm_pkg::IMAGE_FILL;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         ram_enabled_ff     <= 1'b0;
         rom_bank_low_ff    <= ccbm_pkg::ROM_LOW_RESET;
         rom_bank_high_ff   <= 1'b0;
         ram_bank_select_ff <= 5'd0;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (rsp_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
         // bank registers change in word order as words leave decode
         if (advance) begin
            ram_enabled_ff     <= ram_enabled_in;
            rom_bank_low_ff    <= rom_bank_low_in;
            rom_bank_high_ff   <= rom_bank_high_in;
            ram_bank_select_ff <= ram_bank_select_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_data;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef ASSERT_OFF
   // bank registers come out of reset with rom bank 1 selected
   a_reset_bank: assert property (@(posedge clock)
      reset |=> rom_bank_low_ff == ccbm_pkg::ROM_LOW_RESET && !ram_enabled_ff)
      else $error("bank registers not at reset values");

   // a stall toward the requester only while a word sits in the request register
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a held word");

   // save ram offsets stay within 16 banks of 8 KiB
   a_ram_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target == ccbm_pkg::TGT_RAM |-> rsp_data.phys_offset[22:17] == 6'd0)
      else $error("save ram offset out of range");

   // forced value is zero unless a read is forced
   a_force_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.force_read |-> rsp_data.forced_value == 8'd0)
      else $error("forced value without force");

   // a word in decode reaches the response register when it is open
   a_advance: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_open |=> rsp_valid_ff)
      else $error("decoded word lost");
`endif

endmodule

>>> dv/ccbm_tb_pkg.sv
// ----------------------------------------------------------------------------
// ccbm_tb_pkg
// bank register tracking and decode checking for the camera cartridge mapper
// ----------------------------------------------------------------------------
package ccbm_tb_pkg;

   import ccbm_pkg::*;

   // bus map edges
   localparam logic [15:0] ENABLE_LAST      = 16'h1FFF;
   localparam logic [15:0] ROM_LOW_LAST     = 16'h2FFF;
   localparam logic [15:0] FIXED_ROM_LAST   = 16'h3FFF;
   localparam logic [15:0] BANKED_ROM_FIRST = 16'h4000;
   localparam logic [15:0] SELECT_LAST      = 16'h5FFF;
   localparam logic [15:0] BANKED_ROM_LAST  = 16'h7FFF;
   localparam logic [15:0] EXT_LAST         = 16'hBFFF;

   class bank_decode_checker;
      logic        ram_on;
      logic [7:0]  rom_low;
      logic        rom_high;
      logic [4:0]  ram_sel;
      rsp_type     due_decodes[$];
      int          bad_words;
      int          seen_words;

      function new();
         ram_on     = 1'b0;
         rom_low    = ROM_LOW_RESET;
         rom_high   = 1'b0;
         ram_sel    = '0;
         bad_words  = 0;
         seen_words = 0;
      endfunction

      function void flag(string msg);
         bad_words++;
         if (bad_words <= 10) $display("mismatch: %s", msg);
      endfunction

      // decode one access and update the bank registers it writes
      function rsp_type decode_access(req_type acc);
         rsp_type     r;
         logic        cam;
         logic [15:0] a;
         a   = acc.bus_address;
         cam = ram_sel[CAMIO_BIT];
         r   = '0;
         r.target = TGT_NONE;
         if (a >= EXT_FIRST && a <= EXT_LAST) begin
            if (cam) begin
               r.target      = TGT_CAMIO;
               r.phys_offset = 23'(a - EXT_FIRST);
            end else if (ram_on) begin
               r.target      = TGT_RAM;
               r.phys_offset = 23'(a - EXT_FIRST) + 23'({ram_sel[3:0], 13'd0});
            end
         end else if (acc.opcode == OP_READ) begin
            if (a <= FIXED_ROM_LAST) begin
               r.target      = TGT_ROM;
               r.phys_offset = 23'(a);
            end else if (a <= BANKED_ROM_LAST) begin
               r.target      = TGT_ROM;
               r.phys_offset = 23'(a - BANKED_ROM_FIRST) + {rom_high, rom_low, 14'd0};
            end
         end else begin
            if (a <= ENABLE_LAST) begin
               ram_on        = (acc.data_byte != 8'h00);
               r.target      = TGT_REG;
               r.phys_offset = REG_RAM_ENABLE;
            end else if (a <= ROM_LOW_LAST) begin
               rom_low       = acc.data_byte;
               r.target      = TGT_REG;
               r.phys_offset = REG_ROM_LOW;
            end else if (a <= FIXED_ROM_LAST) begin
               rom_high      = acc.data_byte[0];
               r.target      = TGT_REG;
               r.phys_offset = REG_ROM_HIGH;
            end else if (a <= SELECT_LAST) begin
               ram_sel       = acc.data_byte[4:0];
               r.target      = TGT_REG;
               r.phys_offset = REG_RAM_SELECT;
            end
         end
         if (acc.opcode == OP_READ) begin
            if (cam && a >= EXT_FIRST && a <= STATUS_LAST) begin
               r.force_read   = 1'b1;
               r.forced_value = STATUS_FILL;
            end else if (!cam && a >= IMAGE_FIRST && a <= IMAGE_LAST) begin
               r.force_read   = 1'b1;
               r.forced_value = IMAGE_FILL;
            end
         end
         return r;
      endfunction

      function void note_access(req_type acc);
         due_decodes.push_back(decode_access(acc));
      endfunction

      function void check_decode(rsp_type got);
         rsp_type exp;
         string   bad;
         seen_words++;
         if (due_decodes.size() == 0) begin
            flag($sformatf("word %0d with no access waiting: %0d/%06h/%0d/%02h", seen_words,
                           got.target, got.phys_offset, got.force_read, got.forced_value));
            return;
         end
         exp = due_decodes.pop_front();
         bad = "";
         if (got.target !== exp.target) bad = {bad, " target"};
         if (got.phys_offset !== exp.phys_offset) bad = {bad, " phys_offset"};
         if (got.force_read !== exp.force_read) bad = {bad, " force_read"};
         if (got.forced_value !== exp.forced_value) bad = {bad, " forced_value"};
         if (bad != "")
            flag($sformatf("word %0d%s: exp %0d/%06h/%0d/%02h got %0d/%06h/%0d/%02h",
                           seen_words, bad,
                           exp.target, exp.phys_offset, exp.force_read, exp.forced_value,
                           got.target, got.phys_offset, got.force_read, got.forced_value));
      endfunction

      function void check_drained();
         if (due_decodes.size() != 0)
            flag($sformatf("%0d accesses never answered", due_decodes.size()));
      endfunction
   endclass

endpackage

>>> dv/camera_cart_bank_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// camera_cart_bank_mapper_top_tb
// drives bus access words into the mapper with random gaps and response
// stalls, tracks the bank registers alongside and checks every decoded word
// ----------------------------------------------------------------------------
module camera_cart_bank_mapper_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccbm_pkg::*;
   import ccbm_tb_pkg::*;

   localparam int RANDOM_WORDS = 1780;
   localparam int QUIET_WORDS  = 300;   // tail of the run with no idling
   localparam int HOLD_CYCLES  = 80;    // long response hold-off
   localparam int DRAIN_CYCLES = 10;    // extra wait after the last expected word

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   // idling on both sides is allowed while this is set
   logic    idle_on   = 1'b1;
   // asks the response side for one long hold-off
   logic    hold_ask  = 1'b0;

   bank_decode_checker banks;

   camera_cart_bank_mapper_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // build one bus access word
   function automatic req_type access(logic op, logic [15:0] addr, logic [7:0] data);
      req_type w;
      w.opcode      = op;
      w.bus_address = addr;
      w.data_byte   = data;
      return w;
   endfunction

   // random access, weighted toward register writes and the window edges
   function automatic req_type random_access();
      req_type w;
      int      pick;
      pick          = $urandom_range(99, 0);
      w.opcode      = OP_READ;
      w.bus_address = 16'($urandom);
      w.data_byte   = 8'($urandom);
      if (pick < 8) begin
         // ram enable, half of them clear it
         w.opcode      = OP_WRITE;
         w.bus_address = 16'($urandom_range(ENABLE_LAST, 0));
         if ($urandom_range(1, 0) == 0) w.data_byte = 8'h00;
      end else if (pick < 14) begin
         w.opcode      = OP_WRITE;
         w.bus_address = 16'($urandom_range(ROM_LOW_LAST, ENABLE_LAST + 1));
      end else if (pick < 18) begin
         w.opcode      = OP_WRITE;
         w.bus_address = 16'($urandom_range(FIXED_ROM_LAST, ROM_LOW_LAST + 1));
      end else if (pick < 26) begin
         // ram bank select, camera bit set about half the time
         w.opcode      = OP_WRITE;
         w.bus_address = 16'($urandom_range(SELECT_LAST, BANKED_ROM_FIRST));
      end else if (pick < 40) begin
         w.bus_address = 16'($urandom_range(BANKED_ROM_LAST, 0));
      end else if (pick < 66) begin
         // window reads, mostly around the forced areas
         case ($urandom_range(3, 0))
            0:       w.bus_address = 16'($urandom_range(STATUS_LAST + 8, EXT_FIRST));
            1:       w.bus_address = 16'($urandom_range(IMAGE_FIRST + 8, IMAGE_FIRST - 8));
            2:       w.bus_address = 16'($urandom_range(IMAGE_LAST + 8, IMAGE_LAST - 8));
            default: w.bus_address = 16'($urandom_range(EXT_LAST, EXT_FIRST));
         endcase
      end else if (pick < 76) begin
         w.opcode      = OP_WRITE;
         w.bus_address = 16'($urandom_range(EXT_LAST, EXT_FIRST));
      end else if (pick < 86) begin
         // unmapped space either side of the window
         if ($urandom_range(1, 0) == 0)
            w.bus_address = 16'($urandom_range(EXT_FIRST - 1, BANKED_ROM_LAST + 1));
         else
            w.bus_address = 16'($urandom_range(16'hFFFF, EXT_LAST + 1));
         w.opcode = logic'($urandom_range(1, 0));
      end else begin
         w.opcode = logic'($urandom_range(1, 0));
      end
      return w;
   endfunction

   // offer one word from a falling edge, return at the falling edge after it
   // is taken; an idle burst may come first
   task automatic send_access(input req_type w);
      int gap;
      if (idle_on && $urandom_range(4, 0) == 0) begin
         gap = $urandom_range(6, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // response side: short stall bursts, plus one long hold-off on request
   initial begin
      int   stall_left;
      logic hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0)
            stall_left--;
         else if (hold_ask && !hold_done) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
         end else if (idle_on && $urandom_range(5, 0) == 0)
            stall_left = $urandom_range(6, 1);
         rsp_stall <= (stall_left > 0);
      end
   end

   // both channels are observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) banks.note_access(req_data);
         if (rsp_valid && !rsp_stall) banks.check_decode(rsp_data);
      end
   end

   initial begin
      int n;
      banks = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rom reads at reset banks: fixed area edges, banked area with bank 1
      send_access(access(OP_READ, 16'h0000, 8'hFF));
      send_access(access(OP_READ, 16'h3FFF, 8'h00));
      send_access(access(OP_READ, 16'h4000, 8'h00));
      send_access(access(OP_READ, 16'h7FFF, 8'h00));
      // ram still off: window goes nowhere, image area is forced anyway
      send_access(access(OP_READ, 16'hA000, 8'h00));
      send_access(access(OP_READ, 16'hA100, 8'h00));
      // unmapped reads
      send_access(access(OP_READ, 16'h8000, 8'h00));
      send_access(access(OP_READ, 16'hFFFF, 8'h00));
      // turn ram on, read top of bank 0
      send_access(access(OP_WRITE, 16'h0000, 8'h0A));
      send_access(access(OP_READ, 16'hBFFF, 8'h00));
      // rom bank zero is used as written
      send_access(access(OP_WRITE, 16'h2000, 8'h00));
      send_access(access(OP_READ, 16'h4000, 8'h00));
      // highest rom bank, unused data bits of the high bit dropped
      send_access(access(OP_WRITE, 16'h2FFF, 8'hFF));
      send_access(access(OP_WRITE, 16'h3000, 8'hFF));
      send_access(access(OP_READ, 16'h7FFF, 8'h00));
      // ram bank 15, writes in the image area are never forced
      send_access(access(OP_WRITE, 16'h4000, 8'h0F));
      send_access(access(OP_READ, 16'hBFFF, 8'h00));
      send_access(access(OP_WRITE, 16'hA100, 8'h55));
      send_access(access(OP_READ, 16'hAEFF, 8'h00));
      // camera io selected: last status byte forced, the next one not
      send_access(access(OP_WRITE, 16'h5FFF, 8'hFF));
      send_access(access(OP_READ, 16'hA035, 8'h00));
      send_access(access(OP_READ, 16'hA036, 8'h00));
      // unmapped writes, then ram off again
      send_access(access(OP_WRITE, 16'h6000, 8'hFF));
      send_access(access(OP_WRITE, 16'hFFFF, 8'h00));
      send_access(access(OP_WRITE, 16'h1FFF, 8'h00));

      // long hold-off on the response side while words keep coming
      hold_ask = 1'b1;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - QUIET_WORDS) idle_on = 1'b0;
         send_access(random_access());
      end
      req_valid <= 1'b0;

      while (banks.due_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      banks.check_drained();
      if (banks.bad_words == 0)
         $display("[camera_cart_bank_mapper_top] OK");
      else
         $display("[camera_cart_bank_mapper_top] ERROR");
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("[camera_cart_bank_mapper_top] ERROR");
      $finish;
   end

endmodule

>>> camera_cart_bank_mapper_top.f
hdl/ccbm_pkg.sv
hdl/camera_cart_bank_mapper_top.sv
dv/ccbm_tb_pkg.sv
dv/camera_cart_bank_mapper_top_tb.sv
